// ===== src/scfpb_pkg.sv =====
// Shared types and constants for the command FIS and PRD table builder.
package scfpb_pkg;

  localparam logic [7:0] FIS_TYPE_H2D    = 8'h27;
  localparam logic [7:0] OPC_IDENTIFY    = 8'hEC;
  localparam int         FIS_DWORDS      = 5;
  localparam int         CHUNK_BYTES     = 4096;
  localparam int         MAX_PRD_DEFAULT = 8;
  localparam int         QUEUE_DEPTH     = 2;

  localparam int IN_DATA_W  = 144;
  localparam int OUT_DATA_W = 120;

  typedef enum logic {
    REC_FIS = 1'b0,
    REC_PRD = 1'b1
  } rec_kind_e;

  // Classified command: the first four FIS dwords (the fifth is always zero),
  // the buffer base, the size of the final PRD chunk minus one, and the
  // write flag.
  typedef struct packed {
    logic [3:0][31:0] fis;
    logic [63:0]      base;
    logic [11:0]      tail_bcm1;
    logic             wr;
  } cmd_t;

  typedef struct packed {
    rec_kind_e   kind;
    logic [2:0]  index;
    logic [31:0] fis_dword;
    logic [63:0] addr;
    logic [11:0] bcm1;
    logic [3:0]  total;
    logic        wr;
    logic        last;
  } rec_t;

endpackage

// ===== src/scfpb_front.sv =====
// Front end: builds the FIS dwords and the PRD count of one command.
module scfpb_front #(
  parameter int MaxPrd = scfpb_pkg::MAX_PRD_DEFAULT,
  parameter int NprdW  = $clog2(MaxPrd + 1)
) (
  input  logic [7:0]        ata_opcode_i,
  input  logic [47:0]       start_lba_i,
  input  logic [15:0]       sectors_i,
  input  logic [63:0]       buffer_address_i,
  input  logic              write_req_i,
  input  logic              lba48_i,
  output scfpb_pkg::cmd_t   cmd_o,
  output logic [NprdW-1:0]  nprd_o
);
  import scfpb_pkg::*;

  logic        has_lba;
  logic [13:0] chunks;
  logic        sat;
  logic [7:0]  dev_byte;
  logic [7:0]  cnt_hi;

  always_comb begin
    has_lba  = (ata_opcode_i != OPC_IDENTIFY);
    // Eight sectors fill one 4 KiB chunk.
    chunks   = {1'b0, sectors_i[15:3]} + 14'(|sectors_i[2:0]);
    sat      = (chunks > 14'(MaxPrd));
    nprd_o   = sat ? NprdW'(MaxPrd) : NprdW'(chunks);
    dev_byte = lba48_i ? 8'h00 : {4'h0, start_lba_i[27:24]};
    cnt_hi   = lba48_i ? sectors_i[15:8] : 8'h00;

    cmd_o.fis[0] = {8'h00, ata_opcode_i, 1'b0, write_req_i, 6'b0, FIS_TYPE_H2D};
    cmd_o.fis[1] = has_lba ? {dev_byte, start_lba_i[23:0]} : 32'h0;
    cmd_o.fis[2] = (has_lba && lba48_i) ? {8'h00, start_lba_i[47:24]} : 32'h0;
    cmd_o.fis[3] = has_lba ? {16'h0, cnt_hi, sectors_i[7:0]} : 32'h0;
    cmd_o.base   = buffer_address_i;
    cmd_o.wr     = write_req_i;
    // A partial final chunk only exists when the run is not cut short.
    if ((sectors_i[2:0] != 3'd0) && !sat) begin
      cmd_o.tail_bcm1 = {sectors_i[2:0] - 3'd1, 9'h1FF};
    end else begin
      cmd_o.tail_bcm1 = 12'(CHUNK_BYTES - 1);
    end
  end

endmodule

// ===== src/scfpb_queue.sv =====
// Small first-in first-out queue between the front and back ends.
module scfpb_queue #(
  parameter int DataW = 8,
  parameter int Depth = scfpb_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [DataW-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             head_valid_o,
  output logic [DataW-1:0] head_data_o
);
  import scfpb_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [DataW-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  assign full_o       = (count_q == CntW'(Depth));
  assign head_valid_o = (count_q != '0);
  assign head_data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    count_d = count_q + CntW'(push_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i || pop_i) else $error("push into a full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_valid_o) else $error("pop from an empty queue");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth)) else $error("queue count out of range");

endmodule

// ===== src/scfpb_back.sv =====
// Back end: steps through the FIS dwords and PRD entries of the head command.
module scfpb_back #(
  parameter int MaxPrd = scfpb_pkg::MAX_PRD_DEFAULT,
  parameter int NprdW  = $clog2(MaxPrd + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  scfpb_pkg::cmd_t   head_cmd_i,
  input  logic [NprdW-1:0]  head_nprd_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output scfpb_pkg::rec_t   out_rec_o
);
  import scfpb_pkg::*;

  localparam int StepW = $clog2(MaxPrd + FIS_DWORDS);

  logic [StepW-1:0] step_q, step_d;
  logic [StepW-1:0] prd_idx;
  logic [63:0]      addr_q, addr_d;
  logic             out_valid_q, out_valid_d;
  rec_t             rec_q, rec_d;
  logic             advance;
  logic             is_fis;
  logic             rec_last;

  always_comb begin
    advance  = head_valid_i && (!out_valid_q || out_ready_i);
    is_fis   = (step_q < StepW'(FIS_DWORDS));
    prd_idx  = step_q - StepW'(FIS_DWORDS);
    rec_last = (step_q == StepW'(head_nprd_i) + StepW'(FIS_DWORDS - 1));

    rec_d       = rec_q;
    step_d      = step_q;
    addr_d      = addr_q;
    out_valid_d = out_valid_q && !out_ready_i;
    pop_o       = 1'b0;

    if (advance) begin
      out_valid_d    = 1'b1;
      rec_d.total    = 4'(head_nprd_i);
      rec_d.wr       = head_cmd_i.wr;
      rec_d.last     = rec_last;
      if (is_fis) begin
        rec_d.kind      = REC_FIS;
        rec_d.index     = 3'(step_q);
        rec_d.fis_dword = (step_q < StepW'(FIS_DWORDS - 1)) ?
                          head_cmd_i.fis[step_q[1:0]] : 32'h0;
        rec_d.addr      = 64'h0;
        rec_d.bcm1      = 12'h0;
        addr_d          = head_cmd_i.base;
      end else begin
        rec_d.kind      = REC_PRD;
        rec_d.index     = 3'(prd_idx);
        rec_d.fis_dword = 32'h0;
        rec_d.addr      = addr_q;
        rec_d.bcm1      = rec_last ? head_cmd_i.tail_bcm1 : 12'(CHUNK_BYTES - 1);
        addr_d          = addr_q + 64'(CHUNK_BYTES);
      end
      if (rec_last) begin
        step_d = '0;
        pop_o  = 1'b1;
      end else begin
        step_d = step_q + StepW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q  <= rec_d;
    addr_q <= addr_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rec_o   = rec_q;

  a_pop_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> out_valid_q && rec_q.last) else $error("command retired without last");
  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i |-> step_q <= StepW'(head_nprd_i) + StepW'(FIS_DWORDS - 1))
    else $error("record step beyond command");
  a_prd_no_fis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && rec_q.kind == REC_PRD |-> rec_q.fis_dword == 32'h0)
    else $error("PRD record carries FIS data");

endmodule

// ===== src/sata_command_fis_prd_builder.sv =====
// Top level of the host-to-device register FIS and PRD table builder.
//
// Each command transfer on the slave stream produces a run of records on the
// master stream: five FIS dwords, then one PRD entry per 4 KiB chunk of the
// sectors*512 byte buffer, up to MAX_PRD_ENTRIES entries (bytes past that are
// dropped). The run ends with tlast, and its length is five plus the PRD
// count of the command. The back end sequencer emits one record per cycle
// while tready stays high and a command is queued. The front end
// classifies a command in the cycle it is accepted and parks it in a
// two-entry queue, so new commands are taken while earlier runs are still
// going out. The output register is reloaded with the next record in the
// same cycle its current record transfers, so records flow one per cycle
// while tready stays high and the sequencer holds while tready is low. The
// lba48_mode register (one bit, reset to 0) selects the 48-bit FIS layout;
// it should be written only while no command is in flight.
module sata_command_fis_prd_builder #(
  parameter int MAX_PRD_ENTRIES = scfpb_pkg::MAX_PRD_DEFAULT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration write channel: bit 0 is lba48_mode.
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic                             cfg_data_i,
  // Command stream.
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata: ata_opcode[7:0], start_lba[55:8], sectors[71:56],
  // buffer_address[135:72], write_req[136], zero padding above.
  input  logic [scfpb_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // Record stream.
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // tdata: record_index[2:0], fis_dword[34:3], prd_address[98:35],
  // prd_byte_count_minus_one[110:99], prd_total[114:111], write_flag[115],
  // zero padding above.
  output logic [scfpb_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // tuser: record_kind (0 for a FIS dword, 1 for a PRD entry).
  output logic                             m_axis_tuser,
  output logic                             m_axis_tlast
);
  import scfpb_pkg::*;

  localparam int NprdW  = $clog2(MAX_PRD_ENTRIES + 1);
  localparam int QDataW = $bits(cmd_t) + NprdW;

  logic              lba48_q;
  cmd_t              front_cmd;
  logic [NprdW-1:0]  front_nprd;
  logic              q_full;
  logic              q_push;
  logic              q_pop;
  logic              q_valid;
  logic [QDataW-1:0] q_head;
  cmd_t              head_cmd;
  logic [NprdW-1:0]  head_nprd;
  rec_t              rec;

  // The mode register accepts a write in any cycle.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lba48_q <= 1'b0;
    end else if (cfg_valid_i) begin
      lba48_q <= cfg_data_i;
    end
  end

  // A command transfer completes whenever the queue has room.
  assign s_axis_tready = !q_full;
  assign q_push        = s_axis_tvalid && !q_full;

  scfpb_front #(
    .MaxPrd (MAX_PRD_ENTRIES),
    .NprdW  (NprdW)
  ) u_front (
    .ata_opcode_i     (s_axis_tdata[7:0]),
    .start_lba_i      (s_axis_tdata[55:8]),
    .sectors_i        (s_axis_tdata[71:56]),
    .buffer_address_i (s_axis_tdata[135:72]),
    .write_req_i      (s_axis_tdata[136]),
    .lba48_i          (lba48_q),
    .cmd_o            (front_cmd),
    .nprd_o           (front_nprd)
  );

  scfpb_queue #(
    .DataW (QDataW),
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_data_i  ({front_nprd, front_cmd}),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .head_valid_o (q_valid),
    .head_data_o  (q_head)
  );

  assign head_cmd  = q_head[$bits(cmd_t)-1:0];
  assign head_nprd = q_head[QDataW-1:$bits(cmd_t)];

  scfpb_back #(
    .MaxPrd (MAX_PRD_ENTRIES),
    .NprdW  (NprdW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (q_valid),
    .head_cmd_i   (head_cmd),
    .head_nprd_i  (head_nprd),
    .pop_o        (q_pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_rec_o    (rec)
  );

  assign m_axis_tdata = {4'h0, rec.wr, rec.total, rec.bcm1, rec.addr,
                         rec.fis_dword, rec.index};
  assign m_axis_tuser = rec.kind;
  assign m_axis_tlast = rec.last;

endmodule
